### rtl/core/mlnp_pkg.sv
package mlnp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NOTE_W          = 7;
    localparam int ENV_W           = 2;

    localparam logic REQ_NOTE_ON  = 1'b0;
    localparam logic REQ_NOTE_OFF = 1'b1;

    localparam logic [ENV_W-1:0] ENV_NONE    = 2'd0;
    localparam logic [ENV_W-1:0] ENV_ATTACK  = 2'd1;
    localparam logic [ENV_W-1:0] ENV_RELEASE = 2'd2;

    typedef logic [NOTE_W-1:0] t_note;

endpackage

### rtl/core/mlnp_if.sv
interface mlnp_req_if import mlnp_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  req_type;
    t_note note_number;

    modport source (output valid, output req_type, output note_number, input ready);
    modport sink   (input valid, input req_type, input note_number, output ready);
endinterface

interface mlnp_res_if import mlnp_pkg::*; ();
    logic             valid;
    logic             ready;
    t_note            current_note;
    logic             note_active;
    logic             pitch_update;
    logic [ENV_W-1:0] envelope_cmd;

    modport source (output valid, output current_note, output note_active,
                    output pitch_update, output envelope_cmd, input ready);
    modport sink   (input valid, input current_note, input note_active,
                    input pitch_update, input envelope_cmd, output ready);
endinterface

### rtl/core/mlnp_ram.sv
module mlnp_ram import mlnp_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int IDX_W       = $clog2(STACK_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_note            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_note            o_rdata
);

    t_note r_mem [STACK_DEPTH];
    t_note r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mono_last_note_priority.sv
// A note-on of a new note to a full stack is searched and shifted; each entry costs a
// read and a compare, or a read and a write. Events are taken one at a time: the next
// is accepted in the cycle after the result is registered, and a result still waiting
// for transfer holds the sequencer.
// Reset (synchronous, active low) empties the stack and silences the voice.
module mono_last_note_priority import mlnp_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlnp_req_if.sink  i_req,
    mlnp_res_if.source o_res
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_APPEND,
        ST_DECIDE,
        ST_TOP_GET,
        ST_EMIT
    } t_state;

    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_idx,       n_idx;
    logic [CNT_W-1:0] r_count,     n_count;
    t_note            r_snd,       n_snd;
    logic             r_snd_valid, n_snd_valid;
    logic             r_type,      n_type;
    t_note            r_note,      n_note;
    logic             r_pitch,     n_pitch;
    logic [ENV_W-1:0] r_env,       n_env;
    logic             r_out_valid, n_out_valid;
    t_note            r_out_note,  n_out_note;
    logic             r_out_act,   n_out_act;
    logic             r_out_pitch, n_out_pitch;
    logic [ENV_W-1:0] r_out_env,   n_out_env;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_note            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_note            ram_rdata;
    logic [CNT_W-1:0] idx_next;
    logic             is_sounding;

    mlnp_ram #(
        .STACK_DEPTH (STACK_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_next    = r_idx + CNT_W'(1);
    assign is_sounding = r_snd_valid && (r_snd == r_note);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_snd       = r_snd;
        n_snd_valid = r_snd_valid;
        n_type      = r_type;
        n_note      = r_note;
        n_pitch     = r_pitch;
        n_env       = r_env;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_note  = r_out_note;
        n_out_act   = r_out_act;
        n_out_pitch = r_out_pitch;
        n_out_env   = r_out_env;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IDX_W-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_type  = i_req.req_type;
                    n_note  = i_req.note_number;
                    n_idx   = '0;
                    n_pitch = 1'b0;
                    n_env   = ENV_NONE;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                if (r_idx == r_count) begin
                    // not held
                    if (r_type == REQ_NOTE_ON) begin
                        if (r_count == CNT_W'(STACK_DEPTH)) begin
                            // drop the oldest entry first
                            n_idx   = '0;
                            n_state = ST_SH_RD;
                        end else begin
                            n_state = ST_APPEND;
                        end
                    end else begin
                        n_state = ST_DECIDE;
                    end
                end else begin
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (ram_rdata == r_note) begin
                    n_state = (r_type == REQ_NOTE_ON) ? ST_DECIDE : ST_SH_RD;
                end else begin
                    n_idx   = idx_next;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SH_RD: begin
                ram_raddr = idx_next[IDX_W-1:0];
                if (idx_next >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = (r_type == REQ_NOTE_ON) ? ST_APPEND : ST_DECIDE;
                end else begin
                    n_state = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = idx_next;
                n_state   = ST_SH_RD;
            end
            ST_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IDX_W-1:0];
                ram_wdata = r_note;
                n_count   = r_count + CNT_W'(1);
                n_state   = ST_DECIDE;
            end
            ST_DECIDE: begin
                ram_raddr = IDX_W'(r_count - CNT_W'(1));
                n_state   = ST_EMIT;
                if (r_type == REQ_NOTE_ON) begin
                    n_pitch = 1'b1;
                    if (!is_sounding) begin
                        n_snd       = r_note;
                        n_snd_valid = 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_env = ENV_ATTACK;
                        end
                    end
                end else if (is_sounding) begin
                    if (r_count != '0) begin
                        // hand over to the most recent held note
                        n_state = ST_TOP_GET;
                    end else begin
                        n_env       = ENV_RELEASE;
                        n_snd_valid = 1'b0;
                        n_snd       = '0;
                    end
                end
            end
            ST_TOP_GET: begin
                n_snd   = ram_rdata;
                n_pitch = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_note  = r_snd_valid ? r_snd : '0;
                    n_out_act   = r_snd_valid;
                    n_out_pitch = r_pitch;
                    n_out_env   = r_env;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_snd       <= '0;
            r_snd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_snd       <= n_snd;
            r_snd_valid <= n_snd_valid;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_type      <= n_type;
        r_note      <= n_note;
        r_pitch     <= n_pitch;
        r_env       <= n_env;
        r_out_note  <= n_out_note;
        r_out_act   <= n_out_act;
        r_out_pitch <= n_out_pitch;
        r_out_env   <= n_out_env;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.current_note = r_out_note;
    assign o_res.note_active  = r_out_act;
    assign o_res.pitch_update = r_out_pitch;
    assign o_res.envelope_cmd = r_out_env;

endmodule

### sim/tb_mono_last_note_priority.sv
`timescale 1ns / 100ps

module tb_mono_last_note_priority;
    import mlnp_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 200_000;
    localparam int DRAIN_CYCLES = 4 * DEPTH + 30;

    typedef struct packed {
        t_note            current_note;
        logic             note_active;
        logic             pitch_update;
        logic [ENV_W-1:0] envelope_cmd;
    } t_voice_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlnp_req_if req_if ();
    mlnp_res_if res_if ();

    mono_last_note_priority #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Predicted voice state
    t_note stack_notes [DEPTH];
    int    stack_fill;
    t_note voice_note;
    logic  voice_on;

    t_voice_result pending_voice [$];
    int            error_count;
    int            cycle_count;
    int            hold_left;
    logic          no_idle;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: a long hold-off while hold_left counts down, else always ready under no_idle, else random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (no_idle) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= 16);
        end
    end

    function automatic t_voice_result predict_voice(logic kind, t_note note);
        t_voice_result res;
        int            pos;
        res = '0;
        pos = stack_fill;
        for (int i = stack_fill - 1; i >= 0; i--)
            if (stack_notes[i] == note)
                pos = i;
        if (kind == REQ_NOTE_ON) begin
            if (pos == stack_fill) begin
                // full: drop the oldest entry
                if (stack_fill >= DEPTH) begin
                    for (int i = 0; i < DEPTH - 1; i++)
                        stack_notes[i] = stack_notes[i + 1];
                    stack_fill = DEPTH - 1;
                end
                stack_notes[stack_fill] = note;
                stack_fill++;
            end
            if (!voice_on || voice_note != note) begin
                voice_note = note;
                voice_on   = 1'b1;
                if (stack_fill == 1)
                    res.envelope_cmd = ENV_ATTACK;
            end
            res.pitch_update = 1'b1;
        end else begin
            if (pos < stack_fill) begin
                for (int i = pos; i < stack_fill - 1; i++)
                    stack_notes[i] = stack_notes[i + 1];
                stack_fill--;
            end
            if (voice_on && voice_note == note) begin
                // hand over to the newest held note, or release
                if (stack_fill > 0) begin
                    voice_note       = stack_notes[stack_fill - 1];
                    res.pitch_update = 1'b1;
                end else begin
                    res.envelope_cmd = ENV_RELEASE;
                    voice_on         = 1'b0;
                    voice_note       = '0;
                end
            end
        end
        res.current_note = voice_on ? voice_note : '0;
        res.note_active  = voice_on;
        return res;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_voice_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_voice.size() == 0) begin
                $error("result transfer with nothing pending");
                error_count++;
            end else begin
                want = pending_voice.pop_front();
                check_field("current_note", want.current_note, res_if.current_note);
                check_field("note_active", want.note_active, res_if.note_active);
                check_field("pitch_update", want.pitch_update, res_if.pitch_update);
                check_field("envelope_cmd", want.envelope_cmd, res_if.envelope_cmd);
            end
        end
    end

    // Offer one event; leave valid high after the transfer
    task automatic send_event(logic kind, t_note note);
        if (!no_idle) begin
            while ($urandom_range(99) < 16) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.note_number <= note;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        pending_voice.push_back(predict_voice(kind, note));
    endtask

    task automatic test_note_basics();
        send_event(REQ_NOTE_OFF, 7'd127);
        send_event(REQ_NOTE_ON,  7'd0);
        send_event(REQ_NOTE_ON,  7'd127);
        send_event(REQ_NOTE_ON,  7'd127);
        send_event(REQ_NOTE_ON,  7'd64);
        send_event(REQ_NOTE_OFF, 7'd0);
        send_event(REQ_NOTE_OFF, 7'd64);
        send_event(REQ_NOTE_OFF, 7'd127);
    endtask

    task automatic test_stack_overflow();
        for (int i = 0; i <= DEPTH; i++)
            send_event(REQ_NOTE_ON, t_note'(100 + i));
        send_event(REQ_NOTE_OFF, t_note'(100 + DEPTH));
        send_event(REQ_NOTE_OFF, 7'd100);
    endtask

    // Bursts of note-ons mostly from a narrow range, then note-offs mostly of held notes
    task automatic test_random_events(int total, logic calm);
        int    sent;
        int    burst;
        int    lift;
        int    roll;
        int    base;
        t_note pick;
        sent    = 0;
        no_idle <= calm;
        base    = $urandom_range(103);
        while (sent < total) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if ($urandom_range(9) == 0)
                    pick = t_note'($urandom_range(127));
                else
                    pick = t_note'(base + $urandom_range(23));
                send_event(REQ_NOTE_ON, pick);
                sent++;
            end
            lift = $urandom_range(0, burst + 2);
            repeat (lift) begin
                roll = $urandom_range(99);
                if (stack_fill != 0 && roll < 80)
                    pick = stack_notes[$urandom_range(stack_fill - 1)];
                else if (voice_on && roll < 88)
                    pick = voice_note;
                else
                    pick = t_note'($urandom_range(127));
                send_event(REQ_NOTE_OFF, pick);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        no_idle   <= 1'b0;
        hold_left <= 400;
        repeat (30)
            send_event($urandom_range(1) ? REQ_NOTE_OFF : REQ_NOTE_ON,
                       t_note'($urandom_range(127)));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_NOTE_ON;
        req_if.note_number = '0;
        res_if.ready       = 1'b0;
        no_idle            = 1'b0;
        hold_left          = 0;
        error_count        = 0;
        cycle_count        = 0;
        stack_fill         = 0;
        voice_note         = '0;
        voice_on           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_note_basics();
        test_stack_overflow();
        test_random_events(140, 1'b1);
        test_backpressure();
        test_random_events(250, 1'b0);

        req_if.valid <= 1'b0;
        while (pending_voice.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
